// ===== src/ffa_pkg.sv =====
package ffa_pkg;

  localparam int ArenaUnits = 4096;
  localparam int UnitBytes  = 16;
  localparam int IdxW       = 12;
  localparam int CntW       = 13;
  localparam int HdrW       = 2 * CntW;
  localparam int WalkCap    = 3 * ArenaUnits + 8;
  localparam int WalkW      = $clog2(WalkCap + 1);
  localparam int ShiftBytes = $clog2(UnitBytes);
  localparam logic [CntW-1:0] MinGrowReset = CntW'(8);

  localparam logic [0:0] OpAlloc = 1'b0;
  localparam logic [0:0] OpFree  = 1'b1;

  localparam logic [1:0] RegMinGrow = 2'd0;

  typedef struct packed {
    logic [CntW-1:0] next;
    logic [CntW-1:0] size;
  } hdr_t;

endpackage

// ===== src/ffa_ram.sv =====
module ffa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/ffa_seq.sv =====
module ffa_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        op_i,
  input  logic [15:0]                 bytes_i,
  input  logic [ffa_pkg::IdxW-1:0]    addr_i,
  input  logic [ffa_pkg::CntW-1:0]    min_grow_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [ffa_pkg::IdxW-1:0]    res_addr_o,
  output logic                        failed_o,
  output logic [ffa_pkg::CntW-1:0]    free_cnt_o,
  output logic [ffa_pkg::CntW-1:0]    grown_cnt_o
);

  localparam int IW = ffa_pkg::IdxW;
  localparam int CW = ffa_pkg::CntW;
  localparam int WW = ffa_pkg::WalkW;
  localparam logic [CW-1:0] Arena = CW'(ffa_pkg::ArenaUnits);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_INIT  = 12'b000000000010,
    S_ARD   = 12'b000000000100,
    S_AWT   = 12'b000000001000,
    S_ACHK  = 12'b000000010000,
    S_AWR2  = 12'b000000100000,
    S_GROW  = 12'b000001000000,
    S_RRD   = 12'b000010000000,
    S_RWT   = 12'b000100000000,
    S_RCHK  = 12'b001000000000,
    S_RMRG  = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_e;

  // release sub-steps
  typedef enum logic [5:0] {
    R_WALK = 6'b000001,
    R_BP   = 6'b000010,
    R_NX   = 6'b000100,
    R_WBP  = 6'b001000,
    R_P    = 6'b010000,
    R_WP   = 6'b100000
  } rstep_e;

  state_e state_q, state_d;
  rstep_e rs_q, rs_d;
  logic op_q;
  logic [IW-1:0] addr_q;
  logic from_grow_q, from_grow_d;
  logic ready_q, ready_d;
  logic [CW-1:0] rover_q, rover_d, brk_q, brk_d, free_q, free_d, grown_q, grown_d;
  logic [CW-1:0] need_q, need_d, prev_q, prev_d, p_q, p_d, bp_q, bp_d;
  logic [CW-1:0] nx_q, nx_d, bpsz_q, bpsz_d, psz_q, psz_d, nxsz_q, nxsz_d, nxnx_q, nxnx_d;
  logic [CW-1:0] bpn_q, bpn_d;
  logic [IW-1:0] res_q, res_d;
  logic fail_q, fail_d;
  logic [WW-1:0] k_q, k_d;

  logic we;
  logic [IW-1:0] waddr, raddr;
  ffa_pkg::hdr_t wdata, rdata;
  logic [CW-1:0] raddr_full;
  logic [CW-1:0] ra_q;

  ffa_ram #(.Width(ffa_pkg::HdrW), .Depth(ffa_pkg::ArenaUnits)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // out-of-range reads answer zero, a read of the entry being written gets the new word
  logic rd_oob_q;
  logic fwd_q;
  ffa_pkg::hdr_t fwd_data_q;
  ffa_pkg::hdr_t rd;
  assign rd = rd_oob_q ? '0 : (fwd_q ? fwd_data_q : rdata);

  logic [CW-1:0] nu;
  logic [CW:0] grow_sum;
  logic [CW-1:0] split_p;
  assign nu = (need_q < min_grow_i) ? min_grow_i : need_q;
  assign grow_sum = {1'b0, brk_q} + {1'b0, nu};
  assign split_p = p_q + (rd.size - need_q);

  always_comb begin
    state_d = state_q; rs_d = rs_q;
    from_grow_d = from_grow_q; ready_d = ready_q;
    rover_d = rover_q; brk_d = brk_q; free_d = free_q; grown_d = grown_q;
    need_d = need_q; prev_d = prev_q; p_d = p_q; bp_d = bp_q; nx_d = nx_q;
    bpsz_d = bpsz_q; psz_d = psz_q; nxsz_d = nxsz_q; nxnx_d = nxnx_q; bpn_d = bpn_q;
    res_d = res_q; fail_d = fail_q; k_d = k_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr_full = ra_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_d = '0; fail_d = 1'b0;
          need_d = CW'((17'(bytes_i) + 17'(ffa_pkg::UnitBytes - 1))
                       >> ffa_pkg::ShiftBytes) + CW'(1);
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        if (!ready_q) begin
          we = 1'b1; waddr = '0; wdata = '0;
          rover_d = '0; ready_d = 1'b1;
        end
        if (op_q == ffa_pkg::OpAlloc) begin
          prev_d = ready_q ? rover_q : '0;
          raddr_full = ready_q ? rover_q : '0;
          k_d = '0;
          state_d = S_ARD;
        end else if (addr_q >= IW'(2) && CW'(addr_q) - CW'(1) < brk_q) begin
          bp_d = CW'(addr_q) - CW'(1);
          from_grow_d = 1'b0;
          p_d = ready_q ? rover_q : '0; k_d = '0;
          rs_d = R_WALK; state_d = S_RRD;
        end else begin
          state_d = S_DONE;
        end
      end
      // read next of prev
      S_ARD: begin
        p_d = rd.next; raddr_full = rd.next; state_d = S_AWT;
      end
      S_AWT: begin
        state_d = S_ACHK;
      end
      S_ACHK: begin
        if (k_q == WW'(ffa_pkg::WalkCap)) begin
          fail_d = 1'b1; state_d = S_DONE;
        end else if (rd.size >= need_q) begin
          rover_d = prev_q;
          free_d = free_q - need_q;
          if (rd.size == need_q) begin
            // unlink: prev.next = p.next, keep prev size
            nx_d = rd.next;
            raddr_full = prev_q;
            state_d = S_AWR2;
            bpsz_d = '0;
          end else begin
            we = p_q < Arena; waddr = IW'(p_q);
            wdata.next = rd.next; wdata.size = rd.size - need_q;
            bpsz_d = CW'(1);
            p_d = split_p;
            state_d = S_AWR2;
          end
        end else if (p_q == rover_q) begin
          state_d = S_GROW;
        end else begin
          k_d = k_q + WW'(1);
          prev_d = p_q; raddr_full = p_q;
          state_d = S_ARD;
        end
      end
      S_AWR2: begin
        if (bpsz_q != '0) begin
          we = p_q < Arena; waddr = IW'(p_q);
          wdata.next = '0; wdata.size = need_q;
        end else begin
          we = prev_q < Arena; waddr = IW'(prev_q);
          wdata.next = nx_q; wdata.size = rd.size;
        end
        res_d = IW'(p_q + CW'(1));
        fail_d = 1'b0;
        state_d = S_DONE;
      end
      S_GROW: begin
        if (grow_sum > (CW+1)'(ffa_pkg::ArenaUnits)) begin
          fail_d = 1'b1; state_d = S_DONE;
        end else begin
          brk_d = grow_sum[CW-1:0];
          grown_d = grown_q + nu;
          we = brk_q < Arena; waddr = IW'(brk_q);
          wdata.next = '0; wdata.size = nu;
          bp_d = brk_q; from_grow_d = 1'b1;
          p_d = rover_q; k_d = '0; rs_d = R_WALK;
          state_d = S_RRD;
        end
      end
      S_RRD: begin
        case (rs_q)
          R_WALK: raddr_full = p_q;
          R_BP:   raddr_full = bp_q;
          R_NX:   raddr_full = nx_q;
          R_P:    raddr_full = p_q;
          default: raddr_full = p_q;
        endcase
        state_d = S_RWT;
      end
      S_RWT: begin
        state_d = S_RCHK;
      end
      S_RCHK: begin
        case (rs_q)
          R_WALK: begin
            if (k_q == WW'(ffa_pkg::WalkCap) ||
                (p_q < bp_q && bp_q < rd.next) ||
                (p_q >= rd.next && (bp_q > p_q || bp_q < rd.next))) begin
              nx_d = rd.next; rs_d = R_BP;
            end else begin
              p_d = rd.next; k_d = k_q + WW'(1);
            end
            state_d = S_RRD;
          end
          R_BP: begin
            bpsz_d = rd.size; bpn_d = rd.next;
            free_d = free_q + rd.size;
            rs_d = R_NX; state_d = S_RRD;
          end
          R_NX: begin
            nxsz_d = rd.size; nxnx_d = rd.next;
            rs_d = R_WBP; state_d = S_RMRG;
          end
          R_P: begin
            psz_d = rd.size;
            rs_d = R_WP; state_d = S_RMRG;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RMRG: begin
        if (rs_q == R_WBP) begin
          we = bp_q < Arena; waddr = IW'(bp_q);
          if (bp_q + bpsz_q == nx_q) begin
            wdata.size = bpsz_q + nxsz_q; wdata.next = nxnx_q;
          end else begin
            wdata.size = bpsz_q; wdata.next = nx_q;
          end
          bpsz_d = wdata.size; bpn_d = wdata.next;
          rover_d = bp_q;
          rs_d = R_P; state_d = S_RRD;
        end else begin
          we = p_q < Arena; waddr = IW'(p_q);
          if (p_q + psz_q == bp_q) begin
            wdata.size = psz_q + bpsz_q; wdata.next = bpn_q;
            rover_d = p_q;
          end else begin
            wdata.size = psz_q; wdata.next = bp_q;
          end
          if (from_grow_q) begin
            prev_d = rover_d; k_d = k_q + WW'(1);
            raddr_full = rover_d;
            state_d = S_ARD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign raddr = IW'(raddr_full);

  // p is reached via rover after grow: ARD reads rover.next, matching p = next(rover)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; rs_q <= R_WALK; ready_q <= 1'b0;
      rover_q <= '0; brk_q <= CW'(1); free_q <= '0; grown_q <= '0;
      from_grow_q <= 1'b0; rd_oob_q <= 1'b0;
      ra_q <= '0; fwd_q <= 1'b0;
    end else begin
      state_q <= state_d; rs_q <= rs_d; ready_q <= ready_d;
      rover_q <= rover_d; brk_q <= brk_d; free_q <= free_d; grown_q <= grown_d;
      from_grow_q <= from_grow_d;
      rd_oob_q <= raddr_full >= Arena;
      ra_q <= raddr_full;
      fwd_q <= we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      op_q <= op_i;
      addr_q <= addr_i;
    end
    fwd_data_q <= wdata;
    need_q <= need_d; prev_q <= prev_d; p_q <= p_d; bp_q <= bp_d; nx_q <= nx_d;
    bpsz_q <= bpsz_d; psz_q <= psz_d; nxsz_q <= nxsz_d; nxnx_q <= nxnx_d;
    bpn_q <= bpn_d; res_q <= res_d; fail_q <= fail_d; k_q <= k_d;
  end

  assign busy_o      = state_q != S_IDLE;
  assign done_o      = state_q == S_DONE;
  assign res_addr_o  = fail_q ? '0 : res_q;
  assign failed_o    = fail_q;
  assign free_cnt_o  = free_q;
  assign grown_cnt_o = grown_q;

endmodule

// ===== src/first_fit_free_list_allocator_unit.sv =====
// first fit free list allocator
// request channel: in_valid_i / in_stall_o with operation_i, request_bytes_i,
//   block_address_i; allocate when operation is 0, free when 1
// result channel: out_valid_o / out_stall_i with result_address_o, failed_o,
//   free_units_o, arena_units_used_o; one result per request
// one request is worked at a time; in_stall_o is high while it runs
// each list step is one header memory read through a read, a wait and a check state;
//   an allocate walks the list entries and, on growth, walks the list again to insert
//   the new block before it searches anew; a free walks the list to its place, and
//   an ignored free goes straight to its result
// the result sits in an output register; a new request can be taken in the cycle
//   the result appears, and while it is stalled no request is taken
// reset empties the list, sets the break to one and min_grow_units to 8;
//   the header memory needs no clearing, the first request sets the sentinel
// register 0 at paddr 0: min_grow_units, 13 bits
module first_fit_free_list_allocator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [0:0]                 operation_i,
  input  logic [15:0]                request_bytes_i,
  input  logic [ffa_pkg::IdxW-1:0]   block_address_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ffa_pkg::IdxW-1:0]   result_address_o,
  output logic                       failed_o,
  output logic [ffa_pkg::CntW-1:0]   free_units_o,
  output logic [ffa_pkg::CntW-1:0]   arena_units_used_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [1:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [ffa_pkg::CntW-1:0] min_grow_q;
  logic busy, done, fail;
  logic [ffa_pkg::IdxW-1:0] res;
  logic [ffa_pkg::CntW-1:0] fcnt, gcnt;
  logic out_full_q;
  logic start;

  assign pready = 1'b1;
  assign in_stall_o = busy || (out_full_q && out_stall_i);
  assign start = in_valid_i && !in_stall_o;

  ffa_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .op_i       (operation_i[0]),
    .bytes_i    (request_bytes_i),
    .addr_i     (block_address_i),
    .min_grow_i (min_grow_q),
    .busy_o     (busy),
    .done_o     (done),
    .res_addr_o (res),
    .failed_o   (fail),
    .free_cnt_o (fcnt),
    .grown_cnt_o(gcnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_grow_q <= ffa_pkg::MinGrowReset;
      out_full_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == ffa_pkg::RegMinGrow) begin
        min_grow_q <= pwdata[ffa_pkg::CntW-1:0];
      end
      if (done) begin
        out_full_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      result_address_o   <= res;
      failed_o           <= fail;
      free_units_o       <= fcnt;
      arena_units_used_o <= gcnt;
    end
  end

  assign out_valid_o = out_full_q;
  assign prdata = (paddr == ffa_pkg::RegMinGrow) ?
                  32'(min_grow_q) : '0;

endmodule

// ===== tb/ffa_checker.sv =====
`timescale 1ns / 100ps

module ffa_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_o,
  input  logic [0:0]               operation_i,
  input  logic [15:0]              request_bytes_i,
  input  logic [ffa_pkg::IdxW-1:0] block_address_i,
  input  logic                     out_valid_o,
  input  logic                     out_stall_i,
  input  logic [ffa_pkg::IdxW-1:0] result_address_o,
  input  logic                     failed_o,
  input  logic [ffa_pkg::CntW-1:0] free_units_o,
  input  logic [ffa_pkg::CntW-1:0] arena_units_used_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [31:0]              pwdata,
  input  logic                     pready,
  output int                       errors,
  output int                       pending
);

  typedef struct packed {
    logic [ffa_pkg::IdxW-1:0] address;
    logic                     failed;
    logic [ffa_pkg::CntW-1:0] free_units;
    logic [ffa_pkg::CntW-1:0] used_units;
  } alloc_result_t;

  bit [ffa_pkg::CntW-1:0] link_of [ffa_pkg::ArenaUnits];
  bit [ffa_pkg::CntW-1:0] span_of [ffa_pkg::ArenaUnits];
  int unsigned   rover;
  bit            list_set;
  int unsigned   brk;
  int unsigned   free_total;
  int unsigned   grown_total;
  int unsigned   min_grow;
  alloc_result_t result_q[$];

  function automatic int unsigned link_rd(int unsigned i);
    return (i < ffa_pkg::ArenaUnits) ? int'(link_of[i]) : 0;
  endfunction

  function automatic int unsigned span_rd(int unsigned i);
    return (i < ffa_pkg::ArenaUnits) ? int'(span_of[i]) : 0;
  endfunction

  function automatic void link_wr(int unsigned i, int unsigned v);
    if (i < ffa_pkg::ArenaUnits) link_of[i] = v[ffa_pkg::CntW-1:0];
  endfunction

  function automatic void span_wr(int unsigned i, int unsigned v);
    if (i < ffa_pkg::ArenaUnits) span_of[i] = v[ffa_pkg::CntW-1:0];
  endfunction

  function automatic void open_list();
    if (!list_set) begin
      link_wr(0, 0);
      span_wr(0, 0);
      rover = 0;
      list_set = 1;
    end
  endfunction

  function automatic void insert_block(int unsigned bp);
    int unsigned p, nx;
    p = rover;
    for (int k = 0; k < ffa_pkg::WalkCap; k++) begin
      nx = link_rd(p);
      if (p < bp && bp < nx) break;
      if (p >= nx && (bp > p || bp < nx)) break;
      p = nx;
    end
    nx = link_rd(p);
    free_total = (free_total + span_rd(bp)) & 32'h1fff;
    if (bp + span_rd(bp) == nx) begin
      span_wr(bp, span_rd(bp) + span_rd(nx));
      link_wr(bp, link_rd(nx));
    end else begin
      link_wr(bp, nx);
    end
    rover = bp;
    if (p + span_rd(p) == bp) begin
      span_wr(p, span_rd(p) + span_rd(bp));
      link_wr(p, link_rd(bp));
      rover = p;
    end else begin
      link_wr(p, bp);
    end
  endfunction

  function automatic bit grow_arena(int unsigned need);
    int unsigned nu, up;
    nu = (need < min_grow) ? min_grow : need;
    up = brk;
    if (up + nu > ffa_pkg::ArenaUnits) return 0;
    brk = up + nu;
    grown_total = (grown_total + nu) & 32'h1fff;
    span_wr(up, nu);
    insert_block(up);
    return 1;
  endfunction

  function automatic int unsigned first_fit(int unsigned nbytes);
    int unsigned need, prev, p, sz;
    need = (nbytes + ffa_pkg::UnitBytes - 1) / ffa_pkg::UnitBytes + 1;
    open_list();
    prev = rover;
    p = link_rd(prev);
    for (int k = 0; k < ffa_pkg::WalkCap; k++) begin
      sz = span_rd(p);
      if (sz >= need) begin
        if (sz == need) begin
          link_wr(prev, link_rd(p));
        end else begin
          span_wr(p, sz - need);
          p = p + sz - need;
          span_wr(p, need);
        end
        rover = prev;
        free_total = (free_total - need) & 32'h1fff;
        return p + 1;
      end
      if (p == rover) begin
        if (!grow_arena(need)) return 0;
        p = rover;
      end
      prev = p;
      p = link_rd(p);
    end
    return 0;
  endfunction

  function automatic alloc_result_t serve(logic [0:0] op, logic [15:0] nb,
                                          logic [ffa_pkg::IdxW-1:0] ad);
    alloc_result_t r;
    int unsigned a;
    a = 0;
    if (op == ffa_pkg::OpAlloc) begin
      a = first_fit(nb);
    end else begin
      open_list();
      if (ad >= 2 && ad - 1 < brk) insert_block(ad - 1);
    end
    r.address    = a[ffa_pkg::IdxW-1:0];
    r.failed     = (op == ffa_pkg::OpAlloc) && (a == 0);
    r.free_units = free_total[ffa_pkg::CntW-1:0];
    r.used_units = grown_total[ffa_pkg::CntW-1:0];
    return r;
  endfunction

  assign pending = result_q.size();

  always @(negedge clk_i) begin
    alloc_result_t want;
    if (!rst_ni) begin
      rover = 0;
      list_set = 0;
      brk = 1;
      free_total = 0;
      grown_total = 0;
      min_grow = ffa_pkg::MinGrowReset;
      result_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ffa_pkg::RegMinGrow)
        min_grow = pwdata[ffa_pkg::CntW-1:0];
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = result_q.pop_front();
          if (result_address_o !== want.address) begin
            $error("result_address exp %0d got %0d", want.address, result_address_o);
            errors++;
          end
          if (failed_o !== want.failed) begin
            $error("failed exp %0d got %0d", want.failed, failed_o);
            errors++;
          end
          if (free_units_o !== want.free_units) begin
            $error("free_units exp %0d got %0d", want.free_units, free_units_o);
            errors++;
          end
          if (arena_units_used_o !== want.used_units) begin
            $error("arena_units_used exp %0d got %0d", want.used_units, arena_units_used_o);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        result_q.push_back(serve(operation_i, request_bytes_i, block_address_i));
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int CycleLimit = 10000000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [0:0]               operation_i = ffa_pkg::OpAlloc;
  logic [15:0]              request_bytes_i = '0;
  logic [ffa_pkg::IdxW-1:0] block_address_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [ffa_pkg::IdxW-1:0] result_address_o;
  logic                     failed_o;
  logic [ffa_pkg::CntW-1:0] free_units_o;
  logic [ffa_pkg::CntW-1:0] arena_units_used_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [1:0]               paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;

  int          errors;
  int          pending;
  int          cycles = 0;
  bit          quiet = 0;
  logic [ffa_pkg::IdxW-1:0] live_blocks[$];
  int          n_alloc = 0;
  int          n_free = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  first_fit_free_list_allocator_unit i_dut (.*);

  ffa_checker i_checker (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && !quiet && ($urandom_range(99) < 18);
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i && result_address_o != 0)
      live_blocks.push_back(result_address_o);
  end

  task automatic send_request(logic [0:0] op, logic [15:0] nb,
                              logic [ffa_pkg::IdxW-1:0] ad);
    bit taken;
    if (!quiet && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    request_bytes_i <= nb;
    block_address_i <= ad;
    if (op == ffa_pkg::OpAlloc) n_alloc++;
    else n_free++;
    taken = 0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_min_grow(logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ffa_pkg::RegMinGrow;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic free_one_live();
    int idx;
    logic [ffa_pkg::IdxW-1:0] a;
    idx = $urandom_range(live_blocks.size() - 1);
    a = live_blocks[idx];
    live_blocks.delete(idx);
    send_request(ffa_pkg::OpFree, 16'($urandom), a);
  endtask

  initial begin
    int unsigned grow_set[3];
    int unsigned roll;
    logic [15:0] nb;
    grow_set = '{1, 4096, 100};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: sizes at the edges, ignored frees, exact refit, arena overflow
    send_request(ffa_pkg::OpFree, 16'hffff, 12'd0);
    send_request(ffa_pkg::OpAlloc, 16'd0, 12'hfff);
    send_request(ffa_pkg::OpAlloc, 16'd1, '0);
    send_request(ffa_pkg::OpAlloc, 16'd16, '0);
    send_request(ffa_pkg::OpAlloc, 16'd17, '0);
    send_request(ffa_pkg::OpAlloc, 16'd100, '0);
    send_request(ffa_pkg::OpAlloc, 16'hffff, '0);
    send_request(ffa_pkg::OpFree, '0, 12'd1);
    send_request(ffa_pkg::OpFree, '0, 12'hfff);
    wait_drained();
    while (live_blocks.size() > 2) free_one_live();
    send_request(ffa_pkg::OpAlloc, 16'd16, '0);
    send_request(ffa_pkg::OpAlloc, 16'd40, '0);
    send_request(ffa_pkg::OpAlloc, 16'd4000, '0);
    wait_drained();
    while (live_blocks.size() > 0) free_one_live();
    send_request(ffa_pkg::OpAlloc, 16'd32, '0);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      write_min_grow(grow_set[ph]);
      for (int i = 0; i < 450; i++) begin
        quiet = (ph == 0) && (i >= 100) && (i < 400);
        roll = $urandom_range(99);
        if (roll < 2) begin
          send_request(ffa_pkg::OpFree, 16'($urandom), 12'($urandom_range(1)));
        end else if (live_blocks.size() > 0 && roll < 47) begin
          free_one_live();
        end else begin
          roll = $urandom_range(99);
          if (roll < 85) nb = 16'($urandom_range(255));
          else if (roll < 95) nb = 16'($urandom_range(4095));
          else nb = 16'($urandom);
          send_request(ffa_pkg::OpAlloc, nb, 12'($urandom));
        end
      end
      quiet = 0;
      wait_drained();
    end

    repeat (50) @(posedge clk_i);
    $display("covered %0d allocate and %0d free requests over four grow settings",
             n_alloc, n_free);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== first_fit_free_list_allocator_unit.f =====
src/ffa_pkg.sv
src/ffa_ram.sv
src/ffa_seq.sv
src/first_fit_free_list_allocator_unit.sv
tb/ffa_checker.sv
tb/tb_top.sv
